// ===== rtl/gfdi_pkg.sv =====
// Shared types and constants for the gyro frame decoder and angle integrator.
package gfdi_pkg;

	// Frame layout
	localparam int FRAME_BYTES = 8;
	localparam int CNT_W       = $clog2(FRAME_BYTES);
	localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] RATE_HI_IDX  = CNT_W'(FRAME_BYTES - 3);
	localparam logic [CNT_W-1:0] RATE_MID_IDX = CNT_W'(FRAME_BYTES - 2);

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int TIME_W  = 48;
	localparam int RAW_W   = 16;
	localparam int RATE_W  = 25;
	localparam int ANGLE_W = 48;
	localparam int SPAN_W  = 32;
	localparam int SCALE_W = 32;
	localparam int ACC_W   = 64;
	localparam int MUL_W   = 33;

	// Stream payload widths, padded to whole bytes
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 128;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register defaults
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 32'd68590;
	localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 32'd1150752;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_RATE_SCALE  = 1'b0,
		REG_ANGLE_SCALE = 1'b1
	} gfdi_reg_e;

	// One decoded frame handed from front to back
	typedef struct packed {
		logic signed [RAW_W-1:0] rate_raw;
		logic [SPAN_W-1:0]       dt;
		logic [SPAN_W-1:0]       span;
	} gfdi_entry_t;

	// Queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} gfdi_q_status_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RATE,
		BK_DT,
		BK_ACC,
		BK_LO,
		BK_HI,
		BK_SUM
	} gfdi_bk_state_t;

	// Saturate a 48-bit time difference to 32 bits
	function automatic logic [SPAN_W-1:0] sat_span(input logic [TIME_W-1:0] d);
		sat_span = (|d[TIME_W-1:SPAN_W]) ? {SPAN_W{1'b1}} : d[SPAN_W-1:0];
	endfunction

endpackage

// ===== rtl/gfdi_front.sv =====
// Byte assembler: frames serial bytes and hands decoded frames to the queue.
module gfdi_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gfdi_pkg::BYTE_W-1:0]   rx_byte,
	input  logic [gfdi_pkg::TIME_W-1:0]   time_us,
	input  gfdi_pkg::gfdi_q_status_t      q_status,
	output logic                          push,
	output gfdi_pkg::gfdi_entry_t         push_entry
);
	import gfdi_pkg::*;

	logic              in_frame_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] b_hi_q;
	logic [BYTE_W-1:0] b_mid_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] prev_q;
	logic              have_prev_q;
	logic              accept;
	logic              done;
	logic [7:0]        rate_lo;
	logic [7:0]        rate_hi;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign done     = accept && in_frame_q && (cnt_q == LAST_IDX);
	assign push     = done;

	// Rate rebuild from the last three bytes; the final byte is the current one
	assign rate_lo = {rx_byte[7] | b_mid_q[0], rx_byte[6:0]};
	assign rate_hi = {b_hi_q[1:0], b_mid_q[6:1]};

	always_comb begin
		push_entry.rate_raw = $signed({rate_hi, rate_lo});
		push_entry.dt       = have_prev_q ? sat_span(start_q - prev_q) : '0;
		push_entry.span     = sat_span(time_us - start_q);
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			cnt_q       <= '0;
			start_q     <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte[7]) begin
					in_frame_q <= 1'b1;
					cnt_q      <= CNT_W'(1);
					start_q    <= time_us;
				end
			end else if (cnt_q == LAST_IDX) begin
				in_frame_q  <= 1'b0;
				cnt_q       <= '0;
				prev_q      <= start_q;
				have_prev_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Payload bytes that feed the rate field
	always_ff @(posedge clk) begin
		if (accept && in_frame_q) begin
			if (cnt_q == RATE_HI_IDX)  b_hi_q  <= rx_byte;
			if (cnt_q == RATE_MID_IDX) b_mid_q <= rx_byte;
		end
	end

	property p_no_push_full;
		@(posedge clk) disable iff (!arst_n) push |-> !q_status.full;
	endproperty
	a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

	property p_frame_closes;
		@(posedge clk) disable iff (!arst_n) done |=> (!in_frame_q && cnt_q == '0);
	endproperty
	a_frame_closes: assert property (p_frame_closes) else $error("frame not closed");

endmodule

// ===== rtl/gfdi_queue.sv =====
// Short FIFO of decoded frames between the byte assembler and the integrator.
module gfdi_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  gfdi_pkg::gfdi_entry_t    push_entry,
	input  logic                     pop,
	output gfdi_pkg::gfdi_entry_t    pop_entry,
	output gfdi_pkg::gfdi_q_status_t status
);
	import gfdi_pkg::*;

	gfdi_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_entry    = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
			                         : wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
			                         : rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= QCNT_W'(QUEUE_DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("queue overfilled");

endmodule

// ===== rtl/gfdi_back.sv =====
// Integrator: scales the rate, accumulates angle and holds the result register.
module gfdi_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [0:0]                          cfg_index,
	input  logic [gfdi_pkg::SCALE_W-1:0]        cfg_data,
	input  gfdi_pkg::gfdi_q_status_t            q_status,
	input  gfdi_pkg::gfdi_entry_t               pop_entry,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gfdi_pkg::RAW_W-1:0]   rate_raw,
	output logic signed [gfdi_pkg::RATE_W-1:0]  rate_rad_q24,
	output logic signed [gfdi_pkg::ANGLE_W-1:0] angle_rad_q24,
	output logic [gfdi_pkg::SPAN_W-1:0]         frame_span_us
);
	import gfdi_pkg::*;

	gfdi_bk_state_t              state_q, state_d;
	logic [SCALE_W-1:0]          rate_scale_q;
	logic [SCALE_W-1:0]          angle_scale_q;
	logic signed [RAW_W-1:0]     raw_q;
	logic [SPAN_W-1:0]           dt_q;
	logic [SPAN_W-1:0]           span_q;
	logic signed [2*MUL_W-1:0]   prod_q;
	logic signed [RATE_W-1:0]    rate_q;
	logic [ACC_W-1:0]            acc_q;
	logic [SPAN_W-1:0]           lo_q;
	logic                        out_valid_q;
	logic                        out_free;
	logic                        load_out;
	logic signed [MUL_W-1:0]     mul_a;
	logic signed [MUL_W-1:0]     mul_b;
	logic signed [2*MUL_W-1:0]   mul_p;
	logic signed [RATE_W-1:0]    rate_sat;
	logic [ANGLE_W-1:0]          angle_sum;

	assign out_free = !out_valid_q || out_ready;
	assign mul_p    = mul_a * mul_b;

	// Rate scale result: floor shift by 8, then clamp to the Q24 range
	always_comb begin
		if (prod_q[48:32] == {17{prod_q[48]}})
			rate_sat = prod_q[32:8];
		else
			rate_sat = prod_q[48] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
	end

	// Middle bits of the signed 64 x 32 product
	assign angle_sum = {{(ANGLE_W-SPAN_W){1'b0}}, lo_q} + prod_q[ANGLE_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!q_status.empty) state_d = BK_RATE;
			BK_RATE: state_d = BK_DT;
			BK_DT:   state_d = BK_ACC;
			BK_ACC:  state_d = BK_LO;
			BK_LO:   state_d = BK_HI;
			BK_HI:   state_d = BK_SUM;
			BK_SUM:  if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands, queue pop, result load
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			BK_IDLE: pop = !q_status.empty;
			BK_RATE: begin
				mul_a = MUL_W'(raw_q);
				mul_b = $signed({1'b0, rate_scale_q});
			end
			BK_DT: begin
				mul_a = MUL_W'(raw_q);
				mul_b = $signed({1'b0, dt_q});
			end
			BK_LO: begin
				mul_a = $signed({1'b0, acc_q[SCALE_W-1:0]});
				mul_b = $signed({1'b0, angle_scale_q});
			end
			BK_HI: begin
				mul_a = $signed({acc_q[ACC_W-1], acc_q[ACC_W-1:SCALE_W]});
				mul_b = $signed({1'b0, angle_scale_q});
			end
			BK_SUM:  load_out = out_free;
			default: ;
		endcase
	end

	// Control state, accumulator and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			acc_q         <= '0;
			out_valid_q   <= 1'b0;
			rate_scale_q  <= RATE_SCALE_RST;
			angle_scale_q <= ANGLE_SCALE_RST;
		end else begin
			state_q <= state_d;
			if (state_q == BK_ACC) acc_q <= acc_q + prod_q[ACC_W-1:0];
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_wr_en) begin
				case (gfdi_reg_e'(cfg_index))
					REG_RATE_SCALE:  rate_scale_q  <= cfg_data;
					REG_ANGLE_SCALE: angle_scale_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			raw_q  <= pop_entry.rate_raw;
			dt_q   <= pop_entry.dt;
			span_q <= pop_entry.span;
		end
		if (state_q == BK_RATE || state_q == BK_DT || state_q == BK_LO || state_q == BK_HI)
			prod_q <= mul_p;
		if (state_q == BK_DT) rate_q <= rate_sat;
		if (state_q == BK_HI) lo_q <= prod_q[2*SCALE_W-1:SCALE_W];
		if (load_out) begin
			rate_raw      <= raw_q;
			rate_rad_q24  <= rate_q;
			angle_rad_q24 <= $signed(angle_sum);
			frame_span_us <= span_q;
		end
	end

	assign out_valid = out_valid_q;

	property p_pop_starts;
		@(posedge clk) disable iff (!arst_n)
			(state_q == BK_IDLE && !q_status.empty) |=> (state_q == BK_RATE);
	endproperty
	a_pop_starts: assert property (p_pop_starts) else $error("queued frame not taken");

	property p_hold_on_stall;
		@(posedge clk) disable iff (!arst_n)
			(state_q == BK_SUM && out_valid_q && !out_ready) |=> (state_q == BK_SUM && out_valid_q);
	endproperty
	a_hold_on_stall: assert property (p_hold_on_stall) else $error("result lost on stall");

	property p_acc_step;
		@(posedge clk) disable iff (!arst_n)
			(state_q == BK_ACC) |=> (acc_q == $past(acc_q) + $past(prod_q[ACC_W-1:0]));
	endproperty
	a_acc_step: assert property (p_acc_step) else $error("accumulator update wrong");

endmodule

// ===== rtl/gyro_frame_decode_integrate_core.sv =====
// Top level of the gyro frame decoder and angle integrator.
//
// Input stream (s_*): one received serial byte per request with its 48-bit
// microsecond arrival time. A byte with bit 7 set opens an 8-byte frame; idle
// bytes without it are dropped. Output stream (m_*): one result per complete
// frame: raw rate count, rate in rad/s (Q24), integrated angle (Q24) and frame
// span in microseconds. Bytes are taken one per cycle while the frame queue
// has room. A completed frame is queued, then the integrator sequences one
// shared 33 x 33 multiplier through rate scaling, rate-times-delta, and the
// two halves of the angle scaling, and loads the result register once the
// receiver is free; it takes the next frame only after that load.
// A stalled receiver holds the result register; the integrator then waits,
// the two-entry queue fills and s_tready drops until space frees up.
// Reset clears the frame state, the accumulator and the previous-frame mark,
// and loads the default scale registers. The user must write them, through
// cfg_wr_en / cfg_index / cfg_data, only while the block is idle (not enforced).
module gyro_frame_decode_integrate_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [0:0]                      cfg_index,
	input  logic [gfdi_pkg::SCALE_W-1:0]    cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] rx_byte, [55:8] time_us
	input  logic [gfdi_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] rate_raw, [40:16] rate_rad_q24, [88:41] angle_rad_q24,
	// [120:89] frame_span_us, [127:121] zero
	output logic [gfdi_pkg::M_DATA_W-1:0]   m_tdata
);
	import gfdi_pkg::*;

	gfdi_q_status_t          q_status;
	gfdi_entry_t             push_entry;
	gfdi_entry_t             pop_entry;
	logic                    push;
	logic                    pop;
	logic signed [RAW_W-1:0]   rate_raw;
	logic signed [RATE_W-1:0]  rate_rad_q24;
	logic signed [ANGLE_W-1:0] angle_rad_q24;
	logic [SPAN_W-1:0]         frame_span_us;

	gfdi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.rx_byte    (s_tdata[BYTE_W-1:0]),
		.time_us    (s_tdata[BYTE_W+TIME_W-1:BYTE_W]),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	gfdi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	gfdi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_status      (q_status),
		.pop_entry     (pop_entry),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.rate_raw      (rate_raw),
		.rate_rad_q24  (rate_rad_q24),
		.angle_rad_q24 (angle_rad_q24),
		.frame_span_us (frame_span_us)
	);

	// Result packing, first field lowest
	assign m_tdata = {{(M_DATA_W-RAW_W-RATE_W-ANGLE_W-SPAN_W){1'b0}},
	                  frame_span_us, angle_rad_q24, rate_rad_q24, rate_raw};

endmodule

// ===== tb/gfdi_frame_checker.sv =====
// Checker for the gyro frame decoder: predicts each frame result and compares.
`timescale 1ns / 100ps

module gfdi_frame_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [0:0]                    cfg_index,
	input  logic [gfdi_pkg::SCALE_W-1:0]  cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// [7:0] rx_byte, [55:8] time_us
	input  logic [gfdi_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] rate_raw, [40:16] rate_rad_q24, [88:41] angle_rad_q24,
	// [120:89] frame_span_us, [127:121] zero
	input  logic [gfdi_pkg::M_DATA_W-1:0] m_tdata,
	output int                            fails,
	output int                            results_owed
);
	import gfdi_pkg::*;

	localparam longint RATE_Q24_MAX = 64'sd16777215;
	localparam longint RATE_Q24_MIN = -64'sd16777216;

	typedef struct packed {
		logic signed [RAW_W-1:0]   rate_raw;
		logic signed [RATE_W-1:0]  rate_q24;
		logic signed [ANGLE_W-1:0] angle_q24;
		logic [SPAN_W-1:0]         span_us;
	} frame_result_t;

	frame_result_t awaited_results[$];

	// Predicted block state
	logic [SCALE_W-1:0] rate_scale_q32;
	logic [SCALE_W-1:0] angle_scale_q56;
	logic               in_frame;
	int                 frame_fill;
	logic [7:0]         frame_buf [FRAME_BYTES];
	logic [TIME_W-1:0]  frame_start;
	logic [TIME_W-1:0]  prev_start;
	logic               have_prev;
	logic [ACC_W-1:0]   rate_acc;

	// 48-bit microsecond difference clamped to 32 bits
	function automatic logic [SPAN_W-1:0] clamp_us(input logic [TIME_W-1:0] d);
		return (d > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : d[SPAN_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		fails = fails + 1;
	endtask

	// Feed one received byte; a completed frame queues its expected result
	task automatic decode_gyro_byte(input logic [7:0] b, input logic [TIME_W-1:0] t);
		logic [7:0]              lo;
		logic [7:0]              hi;
		logic signed [RAW_W-1:0] raw;
		longint                  prod;
		longint                  q;
		logic [SPAN_W-1:0]       dt;
		logic signed [127:0]     wide;
		frame_result_t           r;
		if (!in_frame && b[7]) begin
			in_frame    = 1'b1;
			frame_fill  = 0;
			frame_start = t;
		end
		if (in_frame) begin
			frame_buf[frame_fill] = b;
			frame_fill = frame_fill + 1;
			if (frame_fill == FRAME_BYTES) begin
				in_frame   = 1'b0;
				frame_fill = 0;
				// Rate is built from the last three bytes: byte 5 bits 1:0, byte 6 bits 6:0, all of byte 7
				lo  = frame_buf[7] | {frame_buf[6][0], 7'b0};
				hi  = {frame_buf[5][1:0], frame_buf[6][6:1]};
				raw = {hi, lo};
				prod = longint'(raw) * longint'({32'b0, rate_scale_q32});
				q = prod >>> 8;
				if (q > RATE_Q24_MAX)
					q = RATE_Q24_MAX;
				else if (q < RATE_Q24_MIN)
					q = RATE_Q24_MIN;
				// Integrate rate over the start-to-start interval
				if (have_prev) begin
					dt = clamp_us(frame_start - prev_start);
					rate_acc = rate_acc + 64'(longint'(raw) * longint'({32'b0, dt}));
				end
				prev_start = frame_start;
				have_prev  = 1'b1;
				wide = $signed({{64{rate_acc[63]}}, rate_acc})
					* $signed({96'b0, angle_scale_q56});
				r.rate_raw  = raw;
				r.rate_q24  = q[RATE_W-1:0];
				r.angle_q24 = wide[79:32];
				r.span_us   = clamp_us(t - frame_start);
				awaited_results.push_back(r);
			end
		end
	endtask

	task automatic check_result(input logic [M_DATA_W-1:0] d);
		frame_result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch("result with none awaited", d[63:0], 64'd0);
		end else begin
			want = awaited_results.pop_front();
			if (d[15:0] !== want.rate_raw)
				report_mismatch("rate_raw", 64'(d[15:0]), 64'(want.rate_raw));
			if (d[40:16] !== want.rate_q24)
				report_mismatch("rate_rad_q24", 64'(d[40:16]), 64'(want.rate_q24));
			if (d[88:41] !== want.angle_q24)
				report_mismatch("angle_rad_q24", 64'(d[88:41]), 64'(want.angle_q24));
			if (d[120:89] !== want.span_us)
				report_mismatch("frame_span_us", 64'(d[120:89]), 64'(want.span_us));
			if (d[127:121] !== 7'd0)
				report_mismatch("padding", 64'(d[127:121]), 64'd0);
		end
	endtask

	// Watch the channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_scale_q32  = RATE_SCALE_RST;
			angle_scale_q56 = ANGLE_SCALE_RST;
			in_frame        = 1'b0;
			frame_fill      = 0;
			frame_start     = '0;
			prev_start      = '0;
			have_prev       = 1'b0;
			rate_acc        = '0;
			fails           = 0;
			awaited_results.delete();
			results_owed <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_RATE_SCALE:  rate_scale_q32  = cfg_data;
					REG_ANGLE_SCALE: angle_scale_q56 = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_gyro_byte(s_tdata[BYTE_W-1:0], s_tdata[BYTE_W +: TIME_W]);
			results_owed <= awaited_results.size();
		end
	end

endmodule

// ===== tb/gyro_frame_decode_integrate_core_tb.sv =====
// Testbench top for the gyro frame decoder: stimulus, idling control and verdict.
`timescale 1ns / 100ps

module gyro_frame_decode_integrate_core_tb;
	import gfdi_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_BYTES    = 144;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [0:0]          cfg_index;
	logic [SCALE_W-1:0]  cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	// [7:0] rx_byte, [55:8] time_us
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	// [15:0] rate_raw, [40:16] rate_rad_q24, [88:41] angle_rad_q24,
	// [120:89] frame_span_us, [127:121] zero
	logic [M_DATA_W-1:0] m_tdata;

	int                  fails;
	int                  results_owed;
	int                  quiet_cycles;
	int                  sender_idle_pct;
	int                  receiver_stall_pct;
	int                  frame_bytes_sent;
	logic [TIME_W-1:0]   now_us;

	gyro_frame_decode_integrate_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	gfdi_frame_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fails        (fails),
		.results_owed (results_owed)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Watchdog on cycles with no request accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One byte request, with random idle cycles in front of it
	task automatic send_byte(input logic [7:0] b, input logic [TIME_W-1:0] t);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {t, b};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Eight bytes, byte 0 in the low bits, at evenly spaced times
	task automatic send_frame(input logic [63:0] fb, input logic [TIME_W-1:0] t_first,
			input logic [TIME_W-1:0] t_step);
		for (int i = 0; i < FRAME_BYTES; i++)
			send_byte(fb[8*i +: 8], t_first + i * t_step);
		now_us = t_first + 7 * t_step;
	endtask

	// Let every owed result out and the integrator settle
	task automatic drain_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_scales(input logic [SCALE_W-1:0] rate_scale,
			input logic [SCALE_W-1:0] angle_scale);
		drain_block();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_RATE_SCALE;
		cfg_data  <= rate_scale;
		@(negedge clk);
		cfg_index <= REG_ANGLE_SCALE;
		cfg_data  <= angle_scale;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly well-formed frames; some dropped idle bytes and stray bytes
	task automatic random_burst();
		int               roll;
		logic [63:0]      fb;
		logic [TIME_W-1:0] gap;
		logic [TIME_W-1:0] step;
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			fb = {$urandom, $urandom};
			fb[7] = 1'b1;
			gap = ($urandom_range(0, 15) == 0) ? TIME_W'({$urandom, $urandom})
				: TIME_W'($urandom_range(1, 5000));
			step = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom_range(1 << 29, 1 << 30))
				: TIME_W'($urandom_range(0, 400));
			send_frame(fb, now_us + gap, step);
			frame_bytes_sent += FRAME_BYTES;
		end else if (roll < 92) begin
			repeat ($urandom_range(1, 3)) begin
				now_us = now_us + $urandom_range(1, 500);
				send_byte(8'($urandom_range(0, 127)), now_us);
			end
		end else begin
			now_us = now_us + $urandom_range(1, 500);
			send_byte(8'($urandom), now_us);
		end
	endtask

	initial begin
		int ph;
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = REG_RATE_SCALE;
		cfg_data           = '0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		m_tready           = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		quiet_cycles       = 0;
		frame_bytes_sent   = 0;
		now_us             = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle bytes dropped, extreme rates, first frame adds nothing
		send_byte(8'h00, 48'd10);
		send_byte(8'h7F, 48'd20);
		send_frame({8'h7F, 8'h7F, 8'h01, 8'h55, 8'hFF, 8'h00, 8'h80, 8'hFF},
			48'd1000, 48'd1);
		// Interval and span both past 32 bits
		send_frame({8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80},
			48'h1_0000_0000 + 48'd1077, 48'h4000_0000);
		// Start bits inside the frame kept as data; times wrap mid-frame
		send_frame({8{8'hFF}}, 48'hFFFF_FFFF_FFFC, 48'd1);

		// Random: four idling modes, each twice, under varied scales
		for (ph = 0; ph < 8; ph++) begin
			sender_idle_pct    = 0;
			receiver_stall_pct = 0;
			case (ph)
				0: program_scales(RATE_SCALE_RST, ANGLE_SCALE_RST);
				1: program_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: program_scales(32'd0, 32'd0);
				3: program_scales($urandom_range(0, 131072), $urandom);
				4: program_scales($urandom, $urandom_range(0, 4095));
				5: program_scales(32'd1, 32'd1);
				6: program_scales(32'd131072, $urandom);
				default: program_scales($urandom, $urandom);
			endcase
			case (ph % 4)
				1: sender_idle_pct = 54;
				2: receiver_stall_pct = 54;
				3: begin
					sender_idle_pct    = 31;
					receiver_stall_pct = 31;
				end
				default: ;
			endcase
			frame_bytes_sent = 0;
			while (frame_bytes_sent < PHASE_BYTES)
				random_burst();
		end

		drain_block();
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gfdi_pkg.sv
rtl/gfdi_front.sv
rtl/gfdi_queue.sv
rtl/gfdi_back.sv
rtl/gyro_frame_decode_integrate_core.sv
tb/gfdi_frame_checker.sv
tb/gyro_frame_decode_integrate_core_tb.sv
